@@ rtl/bls_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, codes and record types for the line stepper.
// No dependencies.
package bls_pkg;

   localparam int COORD_BITS = 14;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int OUT_BITS   = COORD_BITS + 2;
   localparam int ACC_BITS   = COORD_BITS + 6;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef enum logic [1:0] {
      CASE_DIAG = 2'd0,
      CASE_XMAJ = 2'd1,
      CASE_YMAJ = 2'd2
   } major_type;

   typedef struct packed {
      logic                         op;
      logic signed [COORD_BITS-1:0] x_start;
      logic signed [COORD_BITS-1:0] y_start;
      logic signed [COORD_BITS-1:0] x_end;
      logic signed [COORD_BITS-1:0] y_end;
      logic signed [ERR_BITS-1:0]   error_init;
   } req_type;

   // live line: position, goal, steps, error term and increments, major case and widened box
   typedef struct packed {
      logic signed [OUT_BITS-1:0] cur_x;
      logic signed [OUT_BITS-1:0] cur_y;
      logic signed [OUT_BITS-1:0] goal_x;
      logic signed [OUT_BITS-1:0] goal_y;
      logic signed [1:0]          step_x;
      logic signed [1:0]          step_y;
      logic signed [ACC_BITS-1:0] err;
      logic signed [ACC_BITS-1:0] err_inc;
      logic signed [ACC_BITS-1:0] err_dec;
      major_type                  major;
      logic signed [OUT_BITS-1:0] x_min;
      logic signed [OUT_BITS-1:0] x_max;
      logic signed [OUT_BITS-1:0] y_min;
      logic signed [OUT_BITS-1:0] y_max;
   } line_type;

endpackage

@@ rtl/bls_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels for line requests and emitted points.
// Depends on bls_pkg.
interface bls_req_if import bls_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic signed [COORD_BITS-1:0] x_start;
   logic signed [COORD_BITS-1:0] y_start;
   logic signed [COORD_BITS-1:0] x_end;
   logic signed [COORD_BITS-1:0] y_end;
   logic signed [ERR_BITS-1:0]   error_init;

   modport source (output valid, op, x_start, y_start, x_end, y_end, error_init,
                   input ready);
   modport sink (input valid, op, x_start, y_start, x_end, y_end, error_init,
                 output ready);
endinterface

interface bls_rsp_if import bls_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] x;
   logic signed [OUT_BITS-1:0] y;
   logic                       last;

   modport source (output valid, x, y, last, input ready);
   modport sink (input valid, x, y, last, output ready);
endinterface

@@ rtl/bls_setup.sv @@
`timescale 1ns / 1ps
// Derives a fresh line record from a load request: steps, spans, case, box.
// Depends on bls_pkg.
module bls_setup import bls_pkg::*; (
   input  req_type  req,
   output line_type line_new
);

   logic signed [OUT_BITS-1:0] x1, y1, x2, y2;
   logic signed [OUT_BITS-1:0] dx, dy, adx, ady;
   logic signed [OUT_BITS-1:0] xa, xb, ya, yb;
   logic signed [ACC_BITS-1:0] span2_x, span2_y;

   always_comb begin
      x1 = OUT_BITS'(req.x_start);
      y1 = OUT_BITS'(req.y_start);
      x2 = OUT_BITS'(req.x_end);
      y2 = OUT_BITS'(req.y_end);
      dx = x2 - x1;
      dy = y2 - y1;
      adx = dx[OUT_BITS-1] ? -dx : dx;
      ady = dy[OUT_BITS-1] ? -dy : dy;
      span2_x = ACC_BITS'(adx) <<< 1;
      span2_y = ACC_BITS'(ady) <<< 1;
      // box edges: min - |d| and max + |d| reduce to 2a - b
      xa = (x1 <<< 1) - x2;
      xb = (x2 <<< 1) - x1;
      ya = (y1 <<< 1) - y2;
      yb = (y2 <<< 1) - y1;

      line_new.cur_x  = x1;
      line_new.cur_y  = y1;
      line_new.goal_x = x2;
      line_new.goal_y = y2;
      line_new.step_x = (dx == '0) ? 2'sd0 : (dx[OUT_BITS-1] ? -2'sd1 : 2'sd1);
      line_new.step_y = (dy == '0) ? 2'sd0 : (dy[OUT_BITS-1] ? -2'sd1 : 2'sd1);
      line_new.err    = ACC_BITS'(req.error_init);
      line_new.x_min  = dx[OUT_BITS-1] ? xb : xa;
      line_new.x_max  = dx[OUT_BITS-1] ? xa : xb;
      line_new.y_min  = dy[OUT_BITS-1] ? yb : ya;
      line_new.y_max  = dy[OUT_BITS-1] ? ya : yb;
      if (adx == ady) begin
         line_new.major   = CASE_DIAG;
         line_new.err_inc = '0;
         line_new.err_dec = '0;
      end else if (adx > ady) begin
         line_new.major   = CASE_XMAJ;
         line_new.err_inc = span2_y;
         line_new.err_dec = span2_y - span2_x;
      end else begin
         line_new.major   = CASE_YMAJ;
         line_new.err_inc = span2_x;
         line_new.err_dec = span2_x - span2_y;
      end
   end

endmodule

@@ rtl/bls_step.sv @@
`timescale 1ns / 1ps
// One Bresenham step of the live line, with end and box-exit detection.
// Depends on bls_pkg.
module bls_step import bls_pkg::*; (
   input  line_type line_cur,
   output line_type line_next,
   output logic     fin
);

   logic                       err_pos, mv_x, mv_y, at_goal, in_box;
   logic signed [OUT_BITS-1:0] nx, ny;
   logic signed [ACC_BITS-1:0] err_adj;

   always_comb begin
      err_pos = $signed(line_cur.err) > $signed(ACC_BITS'(0));
      mv_x    = (line_cur.major != CASE_YMAJ) || err_pos;
      mv_y    = (line_cur.major != CASE_XMAJ) || err_pos;
      nx = mv_x ? line_cur.cur_x + OUT_BITS'(line_cur.step_x) : line_cur.cur_x;
      ny = mv_y ? line_cur.cur_y + OUT_BITS'(line_cur.step_y) : line_cur.cur_y;
      err_adj = err_pos ? line_cur.err_dec : line_cur.err_inc;

      line_next       = line_cur;
      line_next.cur_x = nx;
      line_next.cur_y = ny;
      line_next.err   = (line_cur.major == CASE_DIAG) ? line_cur.err
                                                      : line_cur.err + err_adj;

      at_goal = (nx == line_cur.goal_x) && (ny == line_cur.goal_y);
      in_box  = (nx >= line_cur.x_min) && (nx <= line_cur.x_max) &&
                (ny >= line_cur.y_min) && (ny <= line_cur.y_max);
      fin     = at_goal || !in_box;
   end

endmodule

@@ rtl/bresenham_line_stepper_core.sv @@
`timescale 1ns / 1ps
// Bresenham line stepper: load a line, then pull one point per step request.
// Depends on bls_pkg, bls_if, bls_setup and bls_step.
//
// Usage
//   req_bus carries requests. op = load takes start, end and error offset and
//   gives no point; op = step moves the live line one point and emits it on
//   rsp_bus with last set on the end point or on leaving the widened box.
//   A step with no live line is swallowed. A load replaces any live line.
//   A step request passes through the request register, then its point is
//   held in the point register for rsp_bus. Throughput: one request per
//   clock while rsp_bus does not stall.
//   Reset clears the request stage, the point register and the live flag;
//   the block takes requests in the first cycle after reset.
//   If rsp_bus stalls, the point register holds and the one request in the
//   input register waits; req_bus.ready drops only when both are full.
module bresenham_line_stepper_core import bls_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bls_req_if.sink    req_bus,
   bls_rsp_if.source  rsp_bus
);

   req_type                    req_ff, req_in;
   logic                       req_valid_ff, req_valid_in;
   line_type                   line_ff, line_in, line_load, line_step;
   logic                       active_ff, active_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       adv, fire, step_fin, emit;

   bls_setup u_setup (.req(req_ff), .line_new(line_load));
   bls_step  u_step  (.line_cur(line_ff), .line_next(line_step), .fin(step_fin));

   assign adv  = !rsp_valid_ff || rsp_bus.ready;
   assign fire = req_valid_ff && adv;
   assign emit = fire && (req_ff.op == OP_STEP) && active_ff;

   assign req_bus.ready = !req_valid_ff || adv;

   always_comb begin
      req_in.op         = req_bus.op;
      req_in.x_start    = req_bus.x_start;
      req_in.y_start    = req_bus.y_start;
      req_in.x_end      = req_bus.x_end;
      req_in.y_end      = req_bus.y_end;
      req_in.error_init = req_bus.error_init;
      req_valid_in      = req_bus.ready ? req_bus.valid : req_valid_ff;

      line_in   = line_ff;
      active_in = active_ff;
      if (fire && req_ff.op == OP_LOAD) begin
         line_in   = line_load;
         active_in = 1'b1;
      end else if (emit) begin
         line_in   = line_step;
         active_in = !step_fin;
      end

      rsp_valid_in = adv ? emit : rsp_valid_ff;
      rsp_x_in     = emit ? line_step.cur_x : rsp_x_ff;
      rsp_y_in     = emit ? line_step.cur_y : rsp_y_ff;
      rsp_last_in  = emit ? step_fin : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_bus.ready) begin
         req_ff <= req_in;
      end
      line_ff     <= line_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.x     = rsp_x_ff;
   assign rsp_bus.y     = rsp_y_ff;
   assign rsp_bus.last  = rsp_last_ff;

   // a step with no live line leaves the point register empty
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      (fire && req_ff.op == OP_STEP && !active_ff) |=> !rsp_bus.valid)
      else $error("point emitted without a live line");

   // the point flagged last retires the line
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && step_fin) |=> (!active_ff && rsp_bus.valid && rsp_bus.last))
      else $error("line still live after its last point");

   // a load arms the line and gives no point
   a_load: assert property (@(posedge clock) disable iff (reset)
      (fire && req_ff.op == OP_LOAD) |=> (active_ff && !rsp_bus.valid))
      else $error("load did not arm the line cleanly");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for bresenham_line_stepper_core: directed table, then random lines.
// Depends on rtl/bls_pkg.sv, rtl/bls_if.sv and the core RTL.
module tb_top;
   import bls_pkg::*;

   localparam int TOTAL_ITEMS  = 1750;
   localparam int MAX_GAP      = 14;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int PAUSE_AT     = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REQ_BITS     = $bits(req_type);

   typedef struct packed {
      logic                       live;
      logic signed [OUT_BITS-1:0] px;
      logic signed [OUT_BITS-1:0] py;
      logic signed [OUT_BITS-1:0] gx;
      logic signed [OUT_BITS-1:0] gy;
      logic signed [1:0]          sx;
      logic signed [1:0]          sy;
      logic signed [ACC_BITS-1:0] err;
      logic signed [ACC_BITS-1:0] span_x2;
      logic signed [ACC_BITS-1:0] span_y2;
      major_type                  kind;
      logic signed [OUT_BITS-1:0] xlo;
      logic signed [OUT_BITS-1:0] xhi;
      logic signed [OUT_BITS-1:0] ylo;
      logic signed [OUT_BITS-1:0] yhi;
   } line_track_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] x;
      logic signed [OUT_BITS-1:0] y;
      logic                       last;
   } point_type;

   typedef struct packed {
      logic      typed;
      point_type pt;
   } typed_slot_type;

   typedef struct packed {
      req_type   r;
      logic      typed;
      point_type pt;
   } stim_row_type;

   logic clock;
   logic reset;

   bls_req_if req_bus ();
   bls_rsp_if rsp_bus ();

   bresenham_line_stepper_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   line_track_type plan_line;
   line_track_type check_line;
   point_type      pending_points[$];
   typed_slot_type typed_q[$];
   stim_row_type   stim_table[$];

   int errors        = 0;
   int useful_items  = 0;
   int sent_items    = 0;
   int loads_sent    = 0;
   int steps_sent    = 0;
   int points_seen   = 0;
   int lines_ended   = 0;
   int idle_cycles   = 0;
   bit sender_burst  = 0;
   bit paused_once   = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Advances a line by one request; returns 1 when a point is emitted.
   function automatic logic advance_line(inout line_track_type s, input req_type r,
                                         output point_type p);
      logic signed [OUT_BITS-1:0] x1, y1, x2, y2, dx, dy, adx, ady;
      logic                       at_goal, in_box;
      p = '0;
      if (r.op == OP_LOAD) begin
         x1 = OUT_BITS'(r.x_start);
         y1 = OUT_BITS'(r.y_start);
         x2 = OUT_BITS'(r.x_end);
         y2 = OUT_BITS'(r.y_end);
         dx = x2 - x1;
         dy = y2 - y1;
         adx = (dx < 0) ? -dx : dx;
         ady = (dy < 0) ? -dy : dy;
         s.px = x1;
         s.py = y1;
         s.gx = x2;
         s.gy = y2;
         s.sx = (dx > 0) ? 2'sb01 : ((dx < 0) ? 2'sb11 : 2'sb00);
         s.sy = (dy > 0) ? 2'sb01 : ((dy < 0) ? 2'sb11 : 2'sb00);
         s.span_x2 = ACC_BITS'(adx) <<< 1;
         s.span_y2 = ACC_BITS'(ady) <<< 1;
         s.err = ACC_BITS'(r.error_init);
         if (s.span_x2 == s.span_y2) s.kind = CASE_DIAG;
         else if (s.span_x2 > s.span_y2) s.kind = CASE_XMAJ;
         else s.kind = CASE_YMAJ;
         s.xlo = ((x1 < x2) ? x1 : x2) - adx;
         s.xhi = ((x1 > x2) ? x1 : x2) + adx;
         s.ylo = ((y1 < y2) ? y1 : y2) - ady;
         s.yhi = ((y1 > y2) ? y1 : y2) + ady;
         s.live = 1'b1;
         return 1'b0;
      end
      if (!s.live) return 1'b0;
      case (s.kind)
         CASE_XMAJ: begin
            if (s.err > 0) begin
               s.py = s.py + OUT_BITS'(s.sy);
               s.err = s.err - s.span_x2;
            end
            s.px = s.px + OUT_BITS'(s.sx);
            s.err = s.err + s.span_y2;
         end
         CASE_YMAJ: begin
            if (s.err > 0) begin
               s.px = s.px + OUT_BITS'(s.sx);
               s.err = s.err - s.span_y2;
            end
            s.py = s.py + OUT_BITS'(s.sy);
            s.err = s.err + s.span_x2;
         end
         default: begin
            s.px = s.px + OUT_BITS'(s.sx);
            s.py = s.py + OUT_BITS'(s.sy);
         end
      endcase
      at_goal = (s.px == s.gx) && (s.py == s.gy);
      in_box = (s.px >= s.xlo) && (s.px <= s.xhi) && (s.py >= s.ylo) && (s.py <= s.yhi);
      p.x = s.px;
      p.y = s.py;
      p.last = at_goal || !in_box;
      if (p.last) s.live = 1'b0;
      return 1'b1;
   endfunction

   task automatic add_row(input logic op, input int xs, input int ys, input int xe,
                          input int ye, input int ei, input logic typed, input int px,
                          input int py, input logic pl);
      stim_row_type row;
      row.r.op = op;
      row.r.x_start = COORD_BITS'(xs);
      row.r.y_start = COORD_BITS'(ys);
      row.r.x_end = COORD_BITS'(xe);
      row.r.y_end = COORD_BITS'(ye);
      row.r.error_init = ERR_BITS'(ei);
      row.typed = typed;
      row.pt.x = OUT_BITS'(px);
      row.pt.y = OUT_BITS'(py);
      row.pt.last = pl;
      stim_table = {stim_table, row};
   endtask

   task automatic send_req(input req_type r, input logic typed, input point_type pt);
      point_type      dummy;
      typed_slot_type slot;
      int             gap;
      if (advance_line(plan_line, r, dummy) || r.op == OP_LOAD) useful_items++;
      if (r.op == OP_LOAD) loads_sent++;
      else steps_sent++;
      if (sent_items % 50 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (!paused_once && sent_items == PAUSE_AT) begin
         paused_once = 1;
         req_bus.valid = 1'b0;
         while (pending_points.size() != 0) @(negedge clock);
      end
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      slot.typed = typed;
      slot.pt = pt;
      typed_q = {typed_q, slot};
      req_bus.op = r.op;
      req_bus.x_start = r.x_start;
      req_bus.y_start = r.y_start;
      req_bus.x_end = r.x_end;
      req_bus.y_end = r.y_end;
      req_bus.error_init = r.error_init;
      req_bus.valid = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_items++;
   endtask

   task automatic send_step();
      req_type r;
      r = REQ_BITS'({$urandom, $urandom, $urandom});
      r.op = OP_STEP;
      send_req(r, 1'b0, '0);
   endtask

   // checker: points first, so a request and a point on one edge never pair up
   always @(posedge clock) begin : monitor
      point_type      want;
      point_type      calc;
      typed_slot_type slot;
      req_type        seen;
      logic           acc;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         acc = 1'b0;
         if (rsp_bus.valid && rsp_bus.ready) begin
            acc = 1'b1;
            points_seen++;
            if (rsp_bus.last) lines_ended++;
            if (pending_points.size() == 0) begin
               $display("%0t: point (%0d,%0d) with no request waiting", $time, rsp_bus.x,
                        rsp_bus.y);
               errors++;
            end else begin
               want = pending_points.pop_front();
               if (rsp_bus.x !== want.x) begin
                  $display("%0t: x expected %0d, got %0d", $time, want.x, rsp_bus.x);
                  errors++;
               end
               if (rsp_bus.y !== want.y) begin
                  $display("%0t: y expected %0d, got %0d", $time, want.y, rsp_bus.y);
                  errors++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, want.last,
                           rsp_bus.last);
                  errors++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            acc = 1'b1;
            seen.op = req_bus.op;
            seen.x_start = req_bus.x_start;
            seen.y_start = req_bus.y_start;
            seen.x_end = req_bus.x_end;
            seen.y_end = req_bus.y_end;
            seen.error_init = req_bus.error_init;
            slot = typed_q.pop_front();
            if (advance_line(check_line, seen, calc))
               pending_points = {pending_points, (slot.typed ? slot.pt : calc)};
         end
         idle_cycles <= acc ? 0 : idle_cycles + 1;
      end
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Stalled for %0d cycles with %0d points outstanding", IDLE_LIMIT,
               pending_points.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : rsp_side
      int wait_n;
      int got;
      bit burst;
      bit held;
      got = 0;
      burst = 0;
      held = 0;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (got % 50 == 0) burst = ($urandom_range(0, 3) == 0);
         wait_n = burst ? 0 : $urandom_range(0, MAX_GAP);
         if (!held && got == HOLD_AT) begin
            held = 1;
            wait_n = HOLD_CYCLES;
         end
         if (wait_n > 0) begin
            rsp_bus.ready = 1'b0;
            repeat (wait_n) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got++;
         @(negedge clock);
      end
   end

   initial begin : req_side
      req_type r;
      int      pick, m, xs, ys, xe, ye, dxa, dya, s, e, cap, n;
      plan_line = '0;
      check_line = '0;
      req_bus.valid = 1'b0;
      req_bus.op = OP_LOAD;
      req_bus.x_start = '0;
      req_bus.y_start = '0;
      req_bus.x_end = '0;
      req_bus.y_end = '0;
      req_bus.error_init = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part
      add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 5, 5, 5, 5, 0, 0, 0, 0, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 1, 5, 5, 1);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, 0, 0, 3, 0, 0, 0, 0, 0, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 1, 1, 0, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 1, 2, 0, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 1, 3, 0, 1);
      add_row(OP_LOAD, 0, 0, -2, -2, 0, 0, 0, 0, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 1, -1, -1, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 1, -2, -2, 1);
      add_row(OP_LOAD, 0, 0, 1, 4, 0, 0, 0, 0, 0);
      repeat (4) add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(OP_LOAD, -8192, -8192, 8191, 8191, -65536, 0, 0, 0, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 1, -8191, -8191, 0);
      // reload over a live line
      add_row(OP_LOAD, 8191, 8191, -8192, 0, 65535, 0, 0, 0, 0);
      add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // odd offset misses the end and leaves the box
      add_row(OP_LOAD, 0, 0, 2, 1, 3, 0, 0, 0, 0);
      repeat (4) add_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      foreach (stim_table[i]) send_req(stim_table[i].r, stim_table[i].typed, stim_table[i].pt);

      // random lines, mostly short, most of them walked to the end
      while (useful_items < TOTAL_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            send_step();
         end else begin
            m = (pick == 1) ? 16383 : ((pick <= 2) ? 60 : 12);
            xs = $urandom_range(0, 16383) - 8192;
            ys = $urandom_range(0, 16383) - 8192;
            if (pick == 1) begin
               xe = $urandom_range(0, 16383) - 8192;
               ye = $urandom_range(0, 16383) - 8192;
            end else begin
               xe = xs + $urandom_range(0, 2 * m) - m;
               ye = ys + $urandom_range(0, 2 * m) - m;
               if (xe > 8191 || xe < -8192) xe = 2 * xs - xe;
               if (ye > 8191 || ye < -8192) ye = 2 * ys - ye;
            end
            dxa = (xe > xs) ? xe - xs : xs - xe;
            dya = (ye > ys) ? ye - ys : ys - ye;
            s = 2 * ((dxa > dya) ? dxa : dya) + 1;
            e = $urandom_range(0, 9);
            if (e < 6) e = $urandom_range(0, 2 * s) - s;
            else if (e < 8) e = $urandom_range(0, 8) - 4;
            else e = $urandom_range(0, 131071) - 65536;
            r.op = OP_LOAD;
            r.x_start = COORD_BITS'(xs);
            r.y_start = COORD_BITS'(ys);
            r.x_end = COORD_BITS'(xe);
            r.y_end = COORD_BITS'(ye);
            r.error_init = ERR_BITS'(e);
            send_req(r, 1'b0, '0);
            cap = (pick == 1) ? 30 : 100000;
            if ($urandom_range(0, 9) == 0) cap = $urandom_range(0, 8);
            n = 0;
            while (plan_line.live && n < cap) begin
               send_step();
               n++;
            end
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_step();
         end
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Sent %0d line loads and %0d step requests under random back-pressure;",
               loads_sent, steps_sent);
      $display("checked %0d points, %0d of them closing a line.", points_seen, lines_ended);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
